[hdl/srd_pkg.sv]
`default_nettype none
package srd_pkg;

  // Dead-zone register width and reset values.
  localparam int unsigned DZ_BITS = 15;
  localparam logic [DZ_BITS-1:0] LEFT_DZ_RESET = 15'd7849;
  localparam logic [DZ_BITS-1:0] RIGHT_DZ_RESET = 15'd8689;

  // Output format: Q1.15, full deflection is Q_ONE.
  localparam int unsigned OUT_BITS = 16;
  localparam logic [OUT_BITS-1:0] Q_ONE = 16'd32767;

  // Number of quotient bits produced by the divider chain.
  localparam int unsigned QUO_BITS = 16;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_LEFT_DZ  = 1'b0,
    REG_RIGHT_DZ = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

[hdl/srd_sqrt_cell.sv]
`default_nettype none
// One digit step of a non-restoring-free square root: takes two radicand bits,
// produces one root bit and hands the partial state to the next cell.
module srd_sqrt_cell #(
  parameter int unsigned RAD_W  = 48,
  parameter int unsigned ROOT_W = 24,
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [RAD_W-1:0]    in_rad,
  input  wire logic [ROOT_W+1:0]   in_rem,
  input  wire logic [ROOT_W-1:0]   in_root,
  input  wire logic [SIDE_W-1:0]   in_side,
  output logic                     valid,
  output logic [RAD_W-1:0]         rad,
  output logic [ROOT_W+1:0]        rem,
  output logic [ROOT_W-1:0]        root,
  output logic [SIDE_W-1:0]        side
);

  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              fits;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {in_rem[ROOT_W-1:0], in_rad[RAD_W-1 -: 2]};
    trial  = {in_root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad  <= {in_rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {in_root[ROOT_W-2:0], fits};
      side <= in_side;
    end
  end

endmodule
`default_nettype wire

[hdl/srd_div_cell.sv]
`default_nettype none
// One restoring division step for both axes against a shared divisor.
module srd_div_cell #(
  parameter int unsigned CW     = 56,
  parameter int unsigned SHIFT  = 0,
  parameter int unsigned SIDE_W = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [CW-1:0]                 in_rem_x,
  input  wire logic [CW-1:0]                 in_rem_y,
  input  wire logic [CW-1:0]                 in_div,
  input  wire logic [srd_pkg::QUO_BITS-1:0]  in_q_x,
  input  wire logic [srd_pkg::QUO_BITS-1:0]  in_q_y,
  input  wire logic [SIDE_W-1:0]             in_side,
  output logic                               valid,
  output logic [CW-1:0]                      rem_x,
  output logic [CW-1:0]                      rem_y,
  output logic [CW-1:0]                      div,
  output logic [srd_pkg::QUO_BITS-1:0]       q_x,
  output logic [srd_pkg::QUO_BITS-1:0]       q_y,
  output logic [SIDE_W-1:0]                  side
);

  logic [CW-1:0] trial;
  logic          ge_x;
  logic          ge_y;

  // Compare each remainder with the divisor at this cell's bit weight.
  always_comb begin
    trial = in_div << SHIFT;
    ge_x  = (in_rem_x >= trial);
    ge_y  = (in_rem_y >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x <= ge_x ? (in_rem_x - trial) : in_rem_x;
      rem_y <= ge_y ? (in_rem_y - trial) : in_rem_y;
      div   <= in_div;
      q_x   <= {in_q_x[srd_pkg::QUO_BITS-2:0], ge_x};
      q_y   <= {in_q_y[srd_pkg::QUO_BITS-2:0], ge_y};
      side  <= in_side;
    end
  end

endmodule
`default_nettype wire

[hdl/stick_radial_deadzone_core.sv]
`default_nettype none
// Radial dead zone with linear rescale for one thumbstick sample per request.
// The block takes one request per cycle while the output is not stalled and
// returns one result per request, in order, after two input stages,
// one square-root cell per root bit (AXIS_BITS + 8 cells), three scaling
// stages, sixteen divider cells and the output register. The whole pipeline
// holds while a result waits on a stalled output. Results are Q1.15 with
// 32767 as full deflection; a disconnected pad, a zero vector or a vector
// inside the selected dead zone gives (0, 0). The user must write dead zones
// through the configuration port while no request is in flight (not enforced).
module stick_radial_deadzone_core #(
  parameter int unsigned AXIS_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [0:0]                          cfg_index,
  input  wire logic [srd_pkg::DZ_BITS-1:0]         cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [15:0]                  stick_x,
  input  wire logic signed [15:0]                  stick_y,
  input  wire logic                                use_left_stick,
  input  wire logic                                pad_connected,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [srd_pkg::OUT_BITS-1:0]      out_x,
  output logic signed [srd_pkg::OUT_BITS-1:0]      out_y
);

  localparam int unsigned AB      = AXIS_BITS;
  localparam int unsigned DZW     = srd_pkg::DZ_BITS;
  localparam int unsigned QB      = srd_pkg::QUO_BITS;
  localparam int unsigned QMW     = AB + 15;
  localparam int unsigned M2W     = 2 * AB;
  localparam int unsigned CMPW    = (M2W > 2 * DZW) ? M2W : 2 * DZW;
  localparam int unsigned NW      = M2W + 16;
  localparam int unsigned RB      = AB + 8;
  localparam int unsigned DW      = AB - 1;
  localparam int unsigned NUMW    = AB + 7;
  localparam int unsigned PW      = QMW + NUMW;
  localparam int unsigned DENW    = DW + RB;
  localparam int unsigned CW      = DENW + 17;
  localparam int unsigned DVW     = PW + 2;
  localparam int unsigned SQ_SW   = 2 * QMW + DZW + 3;
  localparam int unsigned DV_SW   = 3;
  localparam logic [15:0] FULL16  = 16'((1 << (AB - 1)) - 1);

  // Pipeline advances whenever the output register is free or being taken.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Dead-zone registers.
  logic [DZW-1:0] left_dz;
  logic [DZW-1:0] right_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= srd_pkg::LEFT_DZ_RESET;
      right_dz <= srd_pkg::RIGHT_DZ_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        srd_pkg::REG_LEFT_DZ:  left_dz  <= cfg_data;
        srd_pkg::REG_RIGHT_DZ: right_dz <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: sign and magnitude of each axis, squares, dead-zone square.
  logic [AB-1:0]  raw_x;
  logic [AB-1:0]  raw_y;
  logic [AB-1:0]  mag_x;
  logic [AB-1:0]  mag_y;
  logic [DZW-1:0] dz_sel;

  always_comb begin
    raw_x  = stick_x[AB-1:0];
    raw_y  = stick_y[AB-1:0];
    mag_x  = raw_x[AB-1] ? (~raw_x + 1'b1) : raw_x;
    mag_y  = raw_y[AB-1] ? (~raw_y + 1'b1) : raw_y;
    dz_sel = use_left_stick ? left_dz : right_dz;
  end

  logic             a_valid;
  logic             a_neg_x;
  logic             a_neg_y;
  logic [AB-1:0]    a_mag_x;
  logic [AB-1:0]    a_mag_y;
  logic [M2W-1:0]   a_sq_x;
  logic [M2W-1:0]   a_sq_y;
  logic [DZW-1:0]   a_dz;
  logic [2*DZW-1:0] a_dz_sq;
  logic             a_pad;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_neg_x <= raw_x[AB-1];
      a_neg_y <= raw_y[AB-1];
      a_mag_x <= mag_x;
      a_mag_y <= mag_y;
      a_sq_x  <= M2W'(mag_x) * M2W'(mag_x);
      a_sq_y  <= M2W'(mag_y) * M2W'(mag_y);
      a_dz    <= dz_sel;
      a_dz_sq <= (2*DZW)'(dz_sel) * (2*DZW)'(dz_sel);
      a_pad   <= pad_connected;
    end
  end

  // Stage B: squared magnitude, zero-result decision, magnitudes times Q_ONE.
  logic [M2W-1:0] m2;
  logic           zero_b;

  always_comb begin
    m2     = a_sq_x + a_sq_y;
    zero_b = !a_pad || (m2 == '0) || (CMPW'(m2) < CMPW'(a_dz_sq));
  end

  logic           b_valid;
  logic [M2W-1:0] b_m2;
  logic [SQ_SW-1:0] b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_m2   <= m2;
      b_side <= {a_neg_x, a_neg_y,
                 QMW'({a_mag_x, 15'b0}) - QMW'(a_mag_x),
                 QMW'({a_mag_y, 15'b0}) - QMW'(a_mag_y),
                 a_dz, zero_b};
    end
  end

  // Square-root chain: root = floor(sqrt(m2 * 65536)).
  logic             sq_valid [0:RB];
  logic [NW-1:0]    sq_rad   [0:RB];
  logic [RB+1:0]    sq_rem   [0:RB];
  logic [RB-1:0]    sq_root  [0:RB];
  logic [SQ_SW-1:0] sq_side  [0:RB];

  assign sq_valid[0] = b_valid;
  assign sq_rad[0]   = {b_m2, 16'b0};
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = b_side;

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    srd_sqrt_cell #(
      .RAD_W  (NW),
      .ROOT_W (RB),
      .SIDE_W (SQ_SW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (sq_valid[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_side[i]),
      .valid    (sq_valid[i+1]),
      .rad      (sq_rad[i+1]),
      .rem      (sq_rem[i+1]),
      .root     (sq_root[i+1]),
      .side     (sq_side[i+1])
    );
  end

  // Stage C: rescale numerator and dead-zone span.
  logic           s_neg_x;
  logic           s_neg_y;
  logic [QMW-1:0] s_qm_x;
  logic [QMW-1:0] s_qm_y;
  logic [DZW-1:0] s_dz;
  logic           s_zero;
  logic [RB-1:0]  s_r;
  logic           sat;
  logic [DW-1:0]  span;
  logic [RB-1:0]  excess;
  logic [NUMW-1:0] span256;
  logic [NUMW-1:0] num;
  logic [DW-1:0]  den_span;

  always_comb begin
    {s_neg_x, s_neg_y, s_qm_x, s_qm_y, s_dz, s_zero} = sq_side[RB];
    s_r     = sq_root[RB];
    sat     = ({1'b0, s_dz} >= FULL16);
    span    = DW'(FULL16 - {1'b0, s_dz});
    excess  = s_r - RB'({s_dz, 8'b0});
    span256 = {span, 8'b0};
    // A dead zone at or beyond full scale saturates every sample outside it.
    if (sat) begin
      num      = NUMW'(256);
      den_span = DW'(1);
    end else begin
      num      = (excess < RB'(span256)) ? NUMW'(excess) : span256;
      den_span = span;
    end
  end

  logic            c_valid;
  logic            c_neg_x;
  logic            c_neg_y;
  logic [QMW-1:0]  c_qm_x;
  logic [QMW-1:0]  c_qm_y;
  logic            c_zero;
  logic [RB-1:0]   c_r;
  logic [NUMW-1:0] c_num;
  logic [DW-1:0]   c_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= sq_valid[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_neg_x <= s_neg_x;
      c_neg_y <= s_neg_y;
      c_qm_x  <= s_qm_x;
      c_qm_y  <= s_qm_y;
      c_zero  <= s_zero;
      c_r     <= s_r;
      c_num   <= num;
      c_d     <= den_span;
    end
  end

  // Stage D: products for both numerators and the shared denominator.
  logic            d_valid;
  logic            d_neg_x;
  logic            d_neg_y;
  logic            d_zero;
  logic [PW-1:0]   d_p_x;
  logic [PW-1:0]   d_p_y;
  logic [DENW-1:0] d_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_neg_x <= c_neg_x;
      d_neg_y <= c_neg_y;
      d_zero  <= c_zero;
      d_p_x   <= PW'(c_qm_x) * PW'(c_num);
      d_den   <= DENW'(c_d) * DENW'(c_r);
      d_p_y   <= PW'(c_qm_y) * PW'(c_num);
    end
  end

  // Stage E: rounded dividends 2p + den over divisor 2den.
  logic [DVW-1:0] dvd_x;
  logic [DVW-1:0] dvd_y;

  always_comb begin
    dvd_x = {d_p_x, 1'b0} + DVW'(d_den);
    dvd_y = {d_p_y, 1'b0} + DVW'(d_den);
  end

  logic             e_valid;
  logic [CW-1:0]    e_rem_x;
  logic [CW-1:0]    e_rem_y;
  logic [CW-1:0]    e_div;
  logic [DV_SW-1:0] e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_rem_x <= CW'(dvd_x);
      e_rem_y <= CW'(dvd_y);
      e_div   <= CW'({d_den, 1'b0});
      e_side  <= {d_neg_x, d_neg_y, d_zero};
    end
  end

  // Divider chain: one quotient bit per cell, most significant first.
  logic             dv_valid [0:QB];
  logic [CW-1:0]    dv_rem_x [0:QB];
  logic [CW-1:0]    dv_rem_y [0:QB];
  logic [CW-1:0]    dv_div   [0:QB];
  logic [QB-1:0]    dv_q_x   [0:QB];
  logic [QB-1:0]    dv_q_y   [0:QB];
  logic [DV_SW-1:0] dv_side  [0:QB];

  assign dv_valid[0] = e_valid;
  assign dv_rem_x[0] = e_rem_x;
  assign dv_rem_y[0] = e_rem_y;
  assign dv_div[0]   = e_div;
  assign dv_q_x[0]   = '0;
  assign dv_q_y[0]   = '0;
  assign dv_side[0]  = e_side;

  for (genvar i = 0; i < QB; i++) begin : g_div
    srd_div_cell #(
      .CW     (CW),
      .SHIFT  (QB - 1 - i),
      .SIDE_W (DV_SW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (dv_valid[i]),
      .in_rem_x (dv_rem_x[i]),
      .in_rem_y (dv_rem_y[i]),
      .in_div   (dv_div[i]),
      .in_q_x   (dv_q_x[i]),
      .in_q_y   (dv_q_y[i]),
      .in_side  (dv_side[i]),
      .valid    (dv_valid[i+1]),
      .rem_x    (dv_rem_x[i+1]),
      .rem_y    (dv_rem_y[i+1]),
      .div      (dv_div[i+1]),
      .q_x      (dv_q_x[i+1]),
      .q_y      (dv_q_y[i+1]),
      .side     (dv_side[i+1])
    );
  end

  // Output stage: limit to full scale, restore the sign, force zeros.
  logic          f_neg_x;
  logic          f_neg_y;
  logic          f_zero;
  logic [QB-1:0] lim_x;
  logic [QB-1:0] lim_y;
  logic [QB-1:0] res_x;
  logic [QB-1:0] res_y;

  always_comb begin
    {f_neg_x, f_neg_y, f_zero} = dv_side[QB];
    lim_x = (dv_q_x[QB] > srd_pkg::Q_ONE) ? srd_pkg::Q_ONE : dv_q_x[QB];
    lim_y = (dv_q_y[QB] > srd_pkg::Q_ONE) ? srd_pkg::Q_ONE : dv_q_y[QB];
    res_x = f_zero ? '0 : (f_neg_x ? (~lim_x + 1'b1) : lim_x);
    res_y = f_zero ? '0 : (f_neg_y ? (~lim_y + 1'b1) : lim_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x <= res_x;
      out_y <= res_y;
    end
  end

endmodule
`default_nettype wire

[tb/srd_checker.sv]
`timescale 1ns / 1ps
// Watches both channels of the dead-zone core, predicts each result and
// compares it with what comes out.
module srd_checker #(
  parameter int unsigned AXIS_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [14:0]           cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic signed [15:0]    stick_x,
  input  wire logic signed [15:0]    stick_y,
  input  wire logic                  use_left_stick,
  input  wire logic                  pad_connected,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic signed [15:0]    out_x,
  input  wire logic signed [15:0]    out_y,
  output int                         fail_count,
  output int                         pending_count,
  output int                         result_count
);

  localparam longint unsigned FULL = (64'd1 << (AXIS_BITS - 1)) - 1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } stick_out_t;

  logic [14:0] left_dz, right_dz;
  stick_out_t expected_q[$];

  // Bit-serial integer square root.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale one axis magnitude by num/den in Q1.15, round half up, limit, re-sign.
  function automatic logic signed [15:0] scale_one(longint signed a,
                                                   longint unsigned num,
                                                   longint unsigned den);
    longint unsigned mag, p, q;
    mag = (a < 0) ? -a : a;
    p = 64'd32767 * mag * num;
    q = (2 * p + den) / (2 * den);
    if (q > 32767) q = 32767;
    return (a < 0) ? -q[15:0] : q[15:0];
  endfunction

  function automatic longint signed axis_value(logic [15:0] raw);
    logic [15:0] v;
    v = raw << (16 - AXIS_BITS);
    return longint'($signed(v)) >>> (16 - AXIS_BITS);
  endfunction

  function automatic stick_out_t condition_stick(logic [15:0] rx, logic [15:0] ry,
                                                 logic left, logic present);
    longint signed x, y;
    longint unsigned dz, m2, r, num, den, d, t;
    stick_out_t o;
    x = axis_value(rx);
    y = axis_value(ry);
    dz = left ? left_dz : right_dz;
    m2 = x * x + y * y;
    o = '0;
    if (!present || m2 == 0 || m2 < dz * dz) return o;
    r = int_sqrt(m2 << 16);
    if (dz >= FULL) begin
      num = 256;
      den = r;
    end else begin
      d = FULL - dz;
      t = r - 256 * dz;
      num = (t < 256 * d) ? t : 256 * d;
      den = d * r;
    end
    o.x = scale_one(x, num, den);
    o.y = scale_one(y, num, den);
    return o;
  endfunction

  always @(posedge clk) begin
    stick_out_t e;
    int fails;
    fails = 0;
    if (rst) begin
      left_dz <= srd_pkg::LEFT_DZ_RESET;
      right_dz <= srd_pkg::RIGHT_DZ_RESET;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
    end else begin
      // Register writes.
      if (cfg_write) begin
        if (cfg_index == srd_pkg::REG_LEFT_DZ) left_dz <= cfg_data;
        else right_dz <= cfg_data;
      end
      // Accepted request: queue its prediction.
      if (in_valid && !in_stall)
        expected_q.push_back(condition_stick(stick_x, stick_y, use_left_stick,
                                             pad_connected));
      // Accepted result: compare with the oldest prediction.
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result x=%0d y=%0d", out_x, out_y);
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (out_x !== e.x) begin
            $error("out_x expected %0d actual %0d", e.x, out_x);
            fails++;
          end
          if (out_y !== e.y) begin
            $error("out_y expected %0d actual %0d", e.y, out_y);
            fails++;
          end
        end
      end
      fail_count <= fail_count + fails;
      pending_count <= expected_q.size();
    end
  end
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the dead-zone core.
module tb;

  localparam int LATENCY = 46;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk, rst;
  logic cfg_write;
  logic [0:0] cfg_index;
  logic [14:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [15:0] stick_x, stick_y;
  logic use_left_stick, pad_connected;
  logic out_valid, out_stall;
  logic signed [15:0] out_x, out_y;
  int fail_count, pending_count, result_count;
  int idle_cycles;
  int sent_count;
  bit steady_phase;

  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  stick_radial_deadzone_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .stick_x(stick_x), .stick_y(stick_y),
    .use_left_stick(use_left_stick), .pad_connected(pad_connected),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y)
  );

  srd_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .stick_x(stick_x), .stick_y(stick_y),
    .use_left_stick(use_left_stick), .pad_connected(pad_connected),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  // The output side stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !steady_phase && ($urandom_range(99) < 31);
  end

  // Watchdog on cycles with no accepted traffic.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: traffic stopped after %0d requests and %0d results",
                 sent_count, result_count);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Send one request, with a random gap before it unless in the steady stretch.
  task automatic send_request(logic [15:0] x, logic [15:0] y, logic left, logic present);
    while (!steady_phase && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    stick_x <= x;
    stick_y <= y;
    use_left_stick <= left;
    pad_connected <= present;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dead_zone(srd_pkg::cfg_reg_t idx, logic [14:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Random sample: mostly spread widely, some near axes, extremes and zero.
  task automatic random_request();
    logic [15:0] x, y;
    int kind;
    kind = $urandom_range(9);
    x = 16'($urandom);
    y = 16'($urandom);
    if (kind == 0) y = 0;
    else if (kind == 1) x = 0;
    else if (kind == 2) begin
      x = ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
      y = ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
    end else if (kind == 3) begin
      x = $signed(16'($urandom_range(4000))) - 16'sd2000;
      y = $signed(16'($urandom_range(4000))) - 16'sd2000;
    end
    send_request(x, y, 1'($urandom_range(1)), ($urandom_range(99) < 90));
  endtask

  initial begin
    logic [14:0] dz_set [5][2];
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = srd_pkg::REG_LEFT_DZ;
    cfg_data = '0;
    in_valid = 1'b0;
    stick_x = '0;
    stick_y = '0;
    use_left_stick = 1'b0;
    pad_connected = 1'b0;
    steady_phase = 1'b0;
    sent_count = 0;
    dz_set = '{'{15'd0, 15'd32766}, '{15'd32766, 15'd0}, '{15'd100, 15'd20000},
               '{15'd32767, 15'd1}, '{15'd4000, 15'd12000}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset dead zones.
    send_request(16'h0000, 16'h0000, 1'b1, 1'b1);
    send_request(16'h7fff, 16'h0000, 1'b1, 1'b1);
    send_request(16'h8000, 16'h0000, 1'b0, 1'b1);
    send_request(16'h0000, 16'h8000, 1'b1, 1'b1);
    send_request(16'h8000, 16'h8000, 1'b0, 1'b1);
    send_request(16'h7fff, 16'h7fff, 1'b1, 1'b1);
    send_request(16'h7fff, 16'h8001, 1'b0, 1'b1);
    send_request(16'h7fff, 16'h7fff, 1'b1, 1'b0);
    send_request(16'd7848, 16'd0, 1'b1, 1'b1);
    send_request(16'd7849, 16'd0, 1'b1, 1'b1);
    send_request(16'd8688, 16'd0, 1'b0, 1'b1);
    send_request(16'd8689, 16'd0, 1'b0, 1'b1);
    send_request(16'd5550, 16'd5550, 1'b1, 1'b1);
    send_request(-16'sd6000, 16'd6200, 1'b0, 1'b1);
    send_request(16'hffff, 16'h0001, 1'b1, 1'b1);
    drain_pipeline();

    // Dead zone of zero, and one at full scale.
    write_dead_zone(srd_pkg::REG_LEFT_DZ, 15'd0);
    write_dead_zone(srd_pkg::REG_RIGHT_DZ, 15'd32767);
    send_request(16'h0000, 16'h0000, 1'b1, 1'b1);
    send_request(16'h0001, 16'h0000, 1'b1, 1'b1);
    send_request(16'h8000, 16'h7fff, 1'b1, 1'b1);
    send_request(16'h7fff, 16'h0000, 1'b0, 1'b1);
    send_request(16'h8000, 16'h8000, 1'b0, 1'b1);
    send_request(16'h0100, 16'hff00, 1'b0, 1'b1);
    drain_pipeline();

    // Random phases across several dead-zone settings.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 5) begin
        write_dead_zone(srd_pkg::REG_LEFT_DZ, dz_set[ph][0]);
        write_dead_zone(srd_pkg::REG_RIGHT_DZ, dz_set[ph][1]);
      end else begin
        write_dead_zone(srd_pkg::REG_LEFT_DZ, 15'($urandom_range(32767)));
        write_dead_zone(srd_pkg::REG_RIGHT_DZ, 15'($urandom_range(32767)));
      end
      steady_phase = (ph == 2);
      for (int i = 0; i < 320; i++) random_request();
      steady_phase = 1'b0;
      drain_pipeline();
    end

    repeat (LATENCY + 10) @(posedge clk);
    $display("tb: %0d requests sent, %0d results checked over eight dead-zone settings",
             sent_count, result_count);
    $display("tb: covered dead zones of zero and full scale, extreme axes, disconnects");
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

[filelist.f]
hdl/srd_pkg.sv
hdl/srd_sqrt_cell.sv
hdl/srd_div_cell.sv
hdl/stick_radial_deadzone_core.sv
tb/srd_checker.sv
tb/tb.sv
